// ----- design/image_download_flash_controller_top_macros.svh -----
// Assertion macros for the image download flash controller.
`ifndef IMAGE_DOWNLOAD_FLASH_CONTROLLER_TOP_MACROS_SVH
`define IMAGE_DOWNLOAD_FLASH_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTH
`define IDFC_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");
`define IDFC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: label");
`else
`define IDFC_ASSERT_IMPL(label, clk, rst_n, prop)
`define IDFC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- design/idfc_pkg.sv -----
// ----------------------------------------------------------------------------
// idfc_pkg: shared constants and types
// Command, result kind and session state codes, geometry constants.
// ----------------------------------------------------------------------------
package idfc_pkg;
  localparam int WordBytes   = 32;
  localparam int SectorBytes = 131072;
  localparam int SectorCount = 7;
  localparam int ChunkMax    = 256;
  localparam int FillW   = $clog2(WordBytes + 1);
  localparam int WordIdxW = $clog2(WordBytes);
  localparam int SectShift = $clog2(SectorBytes);
  localparam int BeatsPerWord = (WordBytes + 7) / 8;
  localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [19:0] SizeLimitRst = 20'd917504;
  localparam logic [19:0] TimeoutRst   = 20'd300000;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_LIMIT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT    = 1'b1;

  typedef enum logic [2:0] {
    CMD_START = 3'd0, CMD_DATA = 3'd1, CMD_COMMIT = 3'd2,
    CMD_FINISH = 3'd3, CMD_TICK = 3'd4, CMD_ABORT = 3'd5
  } cmd_t;
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0, KIND_ERASE = 2'd1, KIND_BEAT = 2'd2, KIND_FLAG = 2'd3
  } kind_t;
  typedef enum logic [2:0] {
    SS_IDLE = 3'd0, SS_STARTED = 3'd1, SS_VERIFY = 3'd2, SS_DONE = 3'd3,
    SS_ERROR = 3'd4
  } sess_t;
endpackage

// ----- design/idfc_ram.sv -----
// ----------------------------------------------------------------------------
// idfc_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module idfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// ----- design/image_download_flash_controller_top.sv -----
// ----------------------------------------------------------------------------
// image_download_flash_controller_top: firmware image download sequencer
// Erases sectors, packs bytes into flash words sent as program beats,
// runs a bit-serial CRC-32/MPEG-2, checks length and CRC, requests flag write.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata = cmd, value, chunk_last
//  out_    | master    | tdata = payload fields, tlast = final result
//  cfg_    | write     | index 0 size_limit, index 1 timeout_ticks
//
// One command is worked at a time. A data byte passes through the CRC
// shifter, which moves one bit a cycle, and then loads the status. A byte
// that fills a word adds a flush step, a sector erase where needed and
// the four beats, each built from a RAM read and a shift for each byte.
// Start issues one erase per sector needed, then the status. Any result
// waits in the output register while the sequencer holds; the next
// command is taken once the status result leaves the output register.
// Reset is synchronous, active low, and needs no clearing pass: the word
// buffer is only read where it was written in the current session or is
// padded.
module image_download_flash_controller_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] cmd, [34:3] value, [35] chunk_last, [39:36] zero
  input  logic [39:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] kind, [2] rejected, [5:3] session_state, [25:6] offset,
  // [27:26] beat_index, [91:28] beat_data, [111:92] image_size,
  // [143:112] image_crc, [163:144] written_bytes, [164] muted, [167:165] zero
  output logic [167:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [idfc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [19:0]  cfg_wdata
);
`include "image_download_flash_controller_top_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_ERASE, S_CRC, S_FLUSH, S_ERASE_W, S_RD, S_BEAT, S_STATUS
  } fsm_t;

  fsm_t fsm_r;
  logic [19:0] size_limit_r, timeout_r;
  idfc_pkg::sess_t sess_r;
  logic [19:0] img_size_r, written_r, cursor_r, idle_r;
  logic [idfc_pkg::FillW-1:0] fill_r;
  logic [idfc_pkg::SectorCount-1:0] erased_r;
  logic [31:0] crc_r, exp_r;
  logic [7:0]  byte_r;
  logic [3:0]  bit_r;
  logic        act_r, flag_r, rej_r, fin_r;
  logic [8:0]  chunk_r;
  logic [2:0]  sect_r, nsect_r;
  logic [1:0]  beat_r;
  logic [2:0]  bsub_r;
  logic [63:0] beat_sh_r;
  logic        ovalid_r, olast_r;
  logic [1:0]  okind_r;
  logic        orej_r;
  logic [19:0] ooff_r;
  logic [1:0]  obidx_r;
  logic [63:0] odata_r;
  logic        oflag_r;

  // word buffer
  logic ram_we;
  logic [idfc_pkg::WordIdxW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_rdata;
  idfc_ram #(.Width(8), .Depth(idfc_pkg::WordBytes)) u_wbuf (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(byte_r),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [2:0] cmd;
  logic [31:0] val;
  logic cl;
  assign cmd = in_tdata[2:0];
  assign val = in_tdata[34:3];
  assign cl  = in_tdata[35];

  logic out_free;
  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (fsm_r == S_IDLE) && out_free;
  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // byte address in the current beat and the word buffer ports
  logic [idfc_pkg::WordIdxW-1:0] rd_idx;
  assign rd_idx = idfc_pkg::WordIdxW'({beat_r, bsub_r});
  assign ram_raddr = rd_idx;
  assign ram_we = (fsm_r == S_CRC) && (bit_r == 4'd0);
  assign ram_waddr = fill_r[idfc_pkg::WordIdxW-1:0];

  logic [2:0] cur_sect;
  assign cur_sect = (cursor_r[19:idfc_pkg::SectShift] >= 3'(idfc_pkg::SectorCount))
                    ? 3'd7 : 3'(cursor_r[19:idfc_pkg::SectShift]);
  logic sect_bad;
  assign sect_bad = cursor_r[19:idfc_pkg::SectShift] >= 3'(idfc_pkg::SectorCount);

  logic [32:0] sz_ceil;
  assign sz_ceil = {1'b0, val} + 33'(idfc_pkg::SectorBytes - 1);

  logic crc_fb;
  assign crc_fb = crc_r[31] ^ byte_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= S_IDLE;
      size_limit_r <= idfc_pkg::SizeLimitRst;
      timeout_r <= idfc_pkg::TimeoutRst;
      sess_r <= idfc_pkg::SS_IDLE;
      img_size_r <= '0; written_r <= '0; cursor_r <= '0; idle_r <= '0;
      fill_r <= '0; erased_r <= '0; crc_r <= '1; act_r <= 1'b0;
      flag_r <= 1'b0; chunk_r <= '0; ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == idfc_pkg::CFG_SIZE_LIMIT) size_limit_r <= cfg_wdata;
        if (cfg_index == idfc_pkg::CFG_TIMEOUT) timeout_r <= cfg_wdata;
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (fsm_r)
        S_IDLE: begin
          if (in_acc) begin
            rej_r <= 1'b0;
            fsm_r <= S_STATUS;
            case (cmd)
              idfc_pkg::CMD_START: begin
                act_r <= 1'b1; idle_r <= '0;
                if (val == 32'd0 || val > {12'd0, size_limit_r}) begin
                  sess_r <= idfc_pkg::SS_ERROR; rej_r <= 1'b1;
                end else begin
                  img_size_r <= val[19:0];
                  written_r <= '0; fill_r <= '0; cursor_r <= '0;
                  erased_r <= '0; flag_r <= 1'b0; chunk_r <= '0; crc_r <= '1;
                  sess_r <= idfc_pkg::SS_STARTED;
                  nsect_r <= (sz_ceil[32:idfc_pkg::SectShift] >
                              (33 - idfc_pkg::SectShift)'(idfc_pkg::SectorCount))
                             ? 3'(idfc_pkg::SectorCount)
                             : 3'(sz_ceil[32:idfc_pkg::SectShift]);
                  sect_r <= '0;
                  fsm_r <= S_ERASE;
                end
              end
              idfc_pkg::CMD_DATA: begin
                if (sess_r != idfc_pkg::SS_STARTED) begin
                  rej_r <= 1'b1;
                end else if (chunk_r >= 9'(idfc_pkg::ChunkMax)) begin
                  rej_r <= 1'b1;
                end else if (written_r >= img_size_r) begin
                  sess_r <= idfc_pkg::SS_ERROR; rej_r <= 1'b1;
                end else begin
                  chunk_r <= chunk_r + 9'd1;
                  byte_r <= val[7:0];
                  bit_r <= '0;
                  written_r <= written_r + 20'd1;
                  act_r <= 1'b1; idle_r <= '0;
                  fsm_r <= S_CRC;
                end
                if (cl) chunk_r <= '0;
              end
              idfc_pkg::CMD_COMMIT: begin
                if (flag_r) begin
                  flag_r <= 1'b0; sess_r <= idfc_pkg::SS_DONE;
                end
              end
              idfc_pkg::CMD_FINISH: begin
                if (sess_r != idfc_pkg::SS_STARTED) begin
                  rej_r <= 1'b1;
                end else if (written_r != img_size_r) begin
                  sess_r <= idfc_pkg::SS_ERROR; rej_r <= 1'b1;
                end else begin
                  act_r <= 1'b1; idle_r <= '0;
                  exp_r <= val; fin_r <= 1'b1;
                  fsm_r <= (fill_r != '0) ? S_FLUSH : S_STATUS;
                  // the CRC is final here, so every padded beat shows the outcome
                  if (crc_r != val) begin
                    sess_r <= idfc_pkg::SS_ERROR; rej_r <= 1'b1;
                  end else begin
                    sess_r <= idfc_pkg::SS_VERIFY;
                    if (fill_r == '0) flag_r <= 1'b1;
                  end
                end
              end
              idfc_pkg::CMD_TICK: begin
                if (act_r && sess_r != idfc_pkg::SS_VERIFY &&
                    sess_r != idfc_pkg::SS_DONE) begin
                  if ((idle_r == '1 ? idle_r : idle_r + 20'd1) >= timeout_r) begin
                    sess_r <= idfc_pkg::SS_IDLE; img_size_r <= '0;
                    written_r <= '0; fill_r <= '0; cursor_r <= '0;
                    erased_r <= '0; crc_r <= '1; act_r <= 1'b0;
                    idle_r <= '0; chunk_r <= '0; flag_r <= 1'b0;
                  end else if (idle_r != '1) begin
                    idle_r <= idle_r + 20'd1;
                  end
                end
              end
              idfc_pkg::CMD_ABORT: begin
                sess_r <= idfc_pkg::SS_IDLE; img_size_r <= '0;
                written_r <= '0; fill_r <= '0; cursor_r <= '0;
                erased_r <= '0; crc_r <= '1; act_r <= 1'b0;
                idle_r <= '0; chunk_r <= '0; flag_r <= 1'b0;
              end
              default: rej_r <= 1'b1;
            endcase
            fin_r <= (cmd == idfc_pkg::CMD_FINISH);
            oflag_r <= (cmd == idfc_pkg::CMD_COMMIT) && flag_r;
          end
        end
        S_ERASE: begin
          // one erase per cycle while the output is free, from sector 0 up
          if (sect_r == nsect_r) begin
            fsm_r <= S_STATUS;
          end else if (out_free) begin
            ovalid_r <= 1'b1; olast_r <= 1'b0; okind_r <= idfc_pkg::KIND_ERASE;
            orej_r <= 1'b0; ooff_r <= 20'(sect_r) << idfc_pkg::SectShift;
            obidx_r <= '0; odata_r <= '0;
            erased_r[sect_r] <= 1'b1;
            sect_r <= sect_r + 3'd1;
          end
        end
        S_CRC: begin
          // shift the byte through the CRC one bit a cycle
          if (bit_r == 4'd0) fill_r <= fill_r + 1'b1;
          if (bit_r == 4'd8) begin
            fsm_r <= (fill_r == idfc_pkg::FillW'(idfc_pkg::WordBytes))
                     ? S_FLUSH : S_STATUS;
          end else begin
            crc_r <= crc_fb ? ({crc_r[30:0], 1'b0} ^ idfc_pkg::CrcPoly)
                            : {crc_r[30:0], 1'b0};
            byte_r <= {byte_r[6:0], 1'b0};
            bit_r <= bit_r + 4'd1;
          end
        end
        S_FLUSH: begin
          beat_r <= '0; bsub_r <= '0;
          if (sect_bad) begin
            sess_r <= idfc_pkg::SS_ERROR; rej_r <= 1'b1;
            fsm_r <= S_STATUS;
          end else begin
            fsm_r <= erased_r[cur_sect] ? S_RD : S_ERASE_W;
          end
        end
        S_ERASE_W: begin
          if (out_free) begin
            ovalid_r <= 1'b1; olast_r <= 1'b0; okind_r <= idfc_pkg::KIND_ERASE;
            orej_r <= 1'b0; ooff_r <= 20'(cur_sect) << idfc_pkg::SectShift;
            obidx_r <= '0; odata_r <= '0;
            erased_r[cur_sect] <= 1'b1;
            fsm_r <= S_RD;
          end
        end
        S_RD: begin
          // address issued; data arrives next cycle
          fsm_r <= S_BEAT;
        end
        S_BEAT: begin
          // collect each byte read from the word buffer into the beat shifter
          beat_sh_r <= {(rd_idx < fill_r[idfc_pkg::WordIdxW-1:0] ||
                         fill_r == idfc_pkg::FillW'(idfc_pkg::WordBytes))
                        ? ram_rdata : 8'hFF, beat_sh_r[63:8]};
          if (bsub_r == 3'd7) begin
            fsm_r <= S_STATUS;
            if (out_free) begin
              ovalid_r <= 1'b1; olast_r <= 1'b0; okind_r <= idfc_pkg::KIND_BEAT;
              orej_r <= 1'b0; ooff_r <= cursor_r; obidx_r <= beat_r;
              odata_r <= {(rd_idx < fill_r[idfc_pkg::WordIdxW-1:0] ||
                           fill_r == idfc_pkg::FillW'(idfc_pkg::WordBytes))
                          ? ram_rdata : 8'hFF, beat_sh_r[63:8]};
              if (beat_r == 2'(idfc_pkg::BeatsPerWord - 1)) begin
                cursor_r <= cursor_r + 20'(idfc_pkg::WordBytes);
                fill_r <= '0;
                if (fin_r && crc_r == exp_r) flag_r <= 1'b1;
              end else begin
                beat_r <= beat_r + 2'd1; bsub_r <= '0;
                fsm_r <= S_RD;
              end
            end else begin
              // hold: replay the last byte once the output frees
              fsm_r <= S_RD;
              beat_sh_r <= beat_sh_r;
            end
          end else begin
            bsub_r <= bsub_r + 3'd1;
            fsm_r <= S_RD;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            ovalid_r <= 1'b1; olast_r <= 1'b1;
            okind_r <= oflag_r ? idfc_pkg::KIND_FLAG : idfc_pkg::KIND_STATUS;
            orej_r <= oflag_r ? 1'b0 : rej_r;
            ooff_r <= '0; obidx_r <= '0; odata_r <= '0;
            fsm_r <= S_IDLE;
          end
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'd0, act_r, written_r,
                       (okind_r == idfc_pkg::KIND_FLAG) ? crc_r : 32'd0,
                       (okind_r == idfc_pkg::KIND_FLAG) ? img_size_r : 20'd0,
                       odata_r, obidx_r, ooff_r, sess_r, orej_r, okind_r};

  `IDFC_ASSERT_NEVER(a_ready_busy, clk, rst_n, in_tready && fsm_r != S_IDLE)
  `IDFC_ASSERT_IMPL(a_stat_last, clk, rst_n,
    (fsm_r == S_STATUS && out_free) |=> (out_tvalid && out_tlast))
  `IDFC_ASSERT_NEVER(a_fill_over, clk, rst_n,
    fill_r > idfc_pkg::FillW'(idfc_pkg::WordBytes))
  `IDFC_ASSERT_IMPL(a_acc_leaves, clk, rst_n, in_acc |=> fsm_r != S_IDLE)
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: image download flash controller testbench
// Drives command transfers through the input stream and checks every result
// transfer against a built-in session model. The stimulus has a directed
// opening, then random download sessions under several register settings,
// with random idle and stall bursts on both streams.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    idfc_pkg::kind_t kind;
    bit          rej;
    bit [2:0]    st;
    bit [19:0]   off;
    bit [1:0]    bidx;
    bit [63:0]   data;
    bit [19:0]   isz;
    bit [31:0]   icrc;
    bit [19:0]   wr;
    bit          muted;
    bit          last;
  } flash_result_t;

  class flash_session_scoreboard;
    flash_result_t expected_q[$];
    flash_result_t burst[$];
    int errors;
    bit [19:0] size_lim = idfc_pkg::SizeLimitRst;
    bit [19:0] timeout  = idfc_pkg::TimeoutRst;
    idfc_pkg::sess_t st;
    bit [19:0] img_size, written, cursor, idle;
    bit [7:0]  wbuf [idfc_pkg::WordBytes];
    int        fill, chunk;
    bit [6:0]  erased;
    bit [31:0] crc;
    bit        active, flag_pend;

    function new();
      clear_session();
    endfunction

    function void configure(bit idx, bit [19:0] val);
      if (idx == idfc_pkg::CFG_SIZE_LIMIT) size_lim = val;
      else timeout = val;
    endfunction

    function void clear_session();
      st = idfc_pkg::SS_IDLE; img_size = 0; written = 0; fill = 0; cursor = 0;
      erased = 0; crc = '1; active = 0; idle = 0; chunk = 0; flag_pend = 0;
    endfunction

    function void touch();
      active = 1; idle = 0;
    endfunction

    function void emit(idfc_pkg::kind_t k, bit rj, bit [19:0] off, bit [1:0] bi,
                       bit [63:0] d, bit [19:0] sz, bit [31:0] c);
      flash_result_t r;
      r.kind = k; r.rej = rj; r.off = off; r.bidx = bi; r.data = d;
      r.isz = sz; r.icrc = c; r.st = 0; r.wr = 0; r.muted = 0; r.last = 0;
      if (burst.size() < 8) burst.push_back(r);
    endfunction

    function void erase_sector(int s);
      erased[s] = 1'b1;
      emit(idfc_pkg::KIND_ERASE, 0, 20'(s * idfc_pkg::SectorBytes), 0, 0, 0, 0);
    endfunction

    // crc-32/mpeg-2, msb first, one byte
    function void crc_byte(bit [7:0] b);
      bit [31:0] c;
      c = crc ^ {b, 24'h0};
      for (int j = 0; j < 8; j++)
        c = c[31] ? ((c << 1) ^ idfc_pkg::CrcPoly) : (c << 1);
      crc = c;
    endfunction

    // pad the word with 0xFF and send it as beats; 0 when it lands past flash
    function bit flush_word();
      int sector;
      bit [63:0] d;
      if (fill == 0) return 1;
      for (int i = fill; i < idfc_pkg::WordBytes; i++) wbuf[i] = 8'hFF;
      sector = cursor / idfc_pkg::SectorBytes;
      if (sector >= idfc_pkg::SectorCount) return 0;
      if (!erased[sector]) erase_sector(sector);
      for (int i = 0; i < idfc_pkg::BeatsPerWord; i++) begin
        d = 0;
        for (int b = 0; b < 8; b++) d[8*b +: 8] = wbuf[i*8 + b];
        emit(idfc_pkg::KIND_BEAT, 0, cursor, 2'(i), d, 0, 0);
      end
      cursor = cursor + idfc_pkg::WordBytes;
      fill = 0;
      return 1;
    endfunction

    function void note_command(bit [2:0] cmd, bit [31:0] val, bit cl);
      bit rej;
      longint n;
      rej = 0;
      burst.delete();
      case (cmd)
        idfc_pkg::CMD_START: begin
          touch();
          if (val == 0 || val > size_lim) begin
            st = idfc_pkg::SS_ERROR; rej = 1;
          end else begin
            img_size = val[19:0]; written = 0; fill = 0; cursor = 0; erased = 0;
            flag_pend = 0; chunk = 0; crc = '1;
            n = (longint'(val) + idfc_pkg::SectorBytes - 1) / idfc_pkg::SectorBytes;
            if (n > idfc_pkg::SectorCount) n = idfc_pkg::SectorCount;
            for (int s = 0; s < n; s++) erase_sector(s);
            st = idfc_pkg::SS_STARTED;
          end
        end
        idfc_pkg::CMD_DATA: begin
          if (st != idfc_pkg::SS_STARTED) rej = 1;
          else if (chunk + 1 > idfc_pkg::ChunkMax) rej = 1;
          else if (written + 1 > img_size) begin
            st = idfc_pkg::SS_ERROR; rej = 1;
          end else begin
            chunk++;
            wbuf[fill] = val[7:0];
            fill++;
            written++;
            crc_byte(val[7:0]);
            touch();
            if (fill >= idfc_pkg::WordBytes && !flush_word()) begin
              st = idfc_pkg::SS_ERROR; rej = 1;
            end
          end
          if (cl) chunk = 0;
        end
        idfc_pkg::CMD_COMMIT: ;
        idfc_pkg::CMD_FINISH: begin
          if (st != idfc_pkg::SS_STARTED) rej = 1;
          else if (written != img_size) begin
            st = idfc_pkg::SS_ERROR; rej = 1;
          end else begin
            st = idfc_pkg::SS_VERIFY;
            touch();
            if (!flush_word() || crc != val) begin
              st = idfc_pkg::SS_ERROR; rej = 1;
            end else flag_pend = 1;
          end
        end
        idfc_pkg::CMD_TICK: begin
          if (active && st != idfc_pkg::SS_VERIFY && st != idfc_pkg::SS_DONE) begin
            if (idle != 20'hFFFFF) idle++;
            if (idle >= timeout) clear_session();
          end
        end
        idfc_pkg::CMD_ABORT: clear_session();
        default: rej = 1;
      endcase
      if (cmd == idfc_pkg::CMD_COMMIT && flag_pend) begin
        flag_pend = 0;
        st = idfc_pkg::SS_DONE;
        emit(idfc_pkg::KIND_FLAG, 0, 0, 0, 0, img_size, crc);
      end else begin
        if (burst.size() >= 8) void'(burst.pop_back());
        emit(idfc_pkg::KIND_STATUS, rej, 0, 0, 0, 0, 0);
      end
      foreach (burst[i]) begin
        burst[i].st = st; burst[i].wr = written; burst[i].muted = active;
        burst[i].last = (i == burst.size() - 1);
        expected_q.push_back(burst[i]);
      end
    endfunction

    function void check_result(logic [167:0] td, logic tl);
      flash_result_t a, e;
      a.kind = idfc_pkg::kind_t'(td[1:0]); a.rej = td[2]; a.st = td[5:3];
      a.off = td[25:6];
      a.bidx = td[27:26]; a.data = td[91:28]; a.isz = td[111:92];
      a.icrc = td[143:112]; a.wr = td[163:144]; a.muted = td[164]; a.last = tl;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result kind=%0d", a.kind);
        return;
      end
      e = expected_q.pop_front();
      if (a.kind != e.kind || a.rej != e.rej || a.st != e.st || a.off != e.off ||
          a.bidx != e.bidx || a.data != e.data || a.isz != e.isz ||
          a.icrc != e.icrc || a.wr != e.wr || a.muted != e.muted ||
          a.last != e.last) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: exp kind=%0d rej=%0d st=%0d off=%h bi=%0d data=%h",
                   e.kind, e.rej, e.st, e.off, e.bidx, e.data);
          $display("       exp isz=%h crc=%h wr=%h muted=%0d last=%0d",
                   e.isz, e.icrc, e.wr, e.muted, e.last);
          $display("       got kind=%0d rej=%0d st=%0d off=%h bi=%0d data=%h",
                   a.kind, a.rej, a.st, a.off, a.bidx, a.data);
          $display("       got isz=%h crc=%h wr=%h muted=%0d last=%0d",
                   a.isz, a.icrc, a.wr, a.muted, a.last);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;    // [2:0] cmd, [34:3] value, [35] chunk_last
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;   // kind, rejected, state, offset, beat, sizes, counts
  logic         out_tlast;
  logic         cfg_we;
  logic [idfc_pkg::CfgIdxW-1:0] cfg_index;
  logic [19:0]  cfg_wdata;

  flash_session_scoreboard sb;
  bit  idling_on;
  int  n_sent;
  int  stall_left;
  longint cycles;

  image_download_flash_controller_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: generous bound on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 800000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: stall in random bursts while idling is enabled.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Move one command transfer; note it in the scoreboard on acceptance.
  task automatic send(bit [2:0] cmd, bit [31:0] val, bit cl = 1'b0);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0, cl, val, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, val, cl);
    n_sent++;
    @(negedge clk);
  endtask

  // Hold until every expected result has arrived and the block has settled.
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, bit [19:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    sb.configure(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Well-formed session; optionally corrupt the crc at finish.
  task automatic good_session(int size, bit bad_crc);
    send(idfc_pkg::CMD_START, size);
    for (int i = 0; i < size; i++) begin
      if ($urandom_range(0, 9) == 0) send(idfc_pkg::CMD_TICK, $urandom);
      send(idfc_pkg::CMD_DATA, $urandom, $urandom_range(0, 7) == 0);
    end
    send(idfc_pkg::CMD_FINISH,
         bad_crc ? sb.crc ^ (32'h1 << $urandom_range(0, 31)) : sb.crc);
    send(idfc_pkg::CMD_COMMIT, $urandom);
    if ($urandom_range(0, 3) == 0) send(idfc_pkg::CMD_COMMIT, $urandom);
  endtask

  task automatic random_part(int count);
    int stop, sz, pick;
    stop = n_sent + count;
    while (n_sent < stop) begin
      pick = $urandom_range(0, 11);
      sz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
      if (sz > sb.size_lim) sz = sb.size_lim;
      if (pick <= 6) good_session(sz, $urandom_range(0, 5) == 0);
      else if (pick == 7) begin
        // overflow the declared size
        send(idfc_pkg::CMD_START, sz);
        repeat (sz + $urandom_range(1, 3))
          send(idfc_pkg::CMD_DATA, $urandom, $urandom_range(0, 1));
        send(idfc_pkg::CMD_FINISH, sb.crc);
      end else if (pick == 8) begin
        // cut short: finish early or abort
        send(idfc_pkg::CMD_START, sz + 2);
        repeat ($urandom_range(0, sz)) send(idfc_pkg::CMD_DATA, $urandom);
        send($urandom_range(0, 1) ? idfc_pkg::CMD_FINISH : idfc_pkg::CMD_ABORT, sb.crc);
      end else if (pick == 9) begin
        repeat ($urandom_range(1, 14))
          send(idfc_pkg::CMD_TICK, $urandom, $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 4)) send(3'($urandom_range(0, 7)), $urandom,
                                           $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    n_sent = 0;
    idling_on = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed opening at reset settings.
    send(idfc_pkg::CMD_START, 0);                 // zero size
    send(idfc_pkg::CMD_START, 32'hFFFF_FFFF);     // size above the limit
    send(idfc_pkg::CMD_DATA, 32'hFFFF_FFFF, 1);   // data outside a session
    send(idfc_pkg::CMD_FINISH, 0);                // finish outside a session
    send(idfc_pkg::CMD_COMMIT, 0);                // nothing to commit
    send(idfc_pkg::CMD_TICK, 0);
    send(3'd6, 32'hA5A5_5A5A, 1);                 // unknown commands
    send(3'd7, 0);
    send(idfc_pkg::CMD_ABORT, 0);
    send(idfc_pkg::CMD_TICK, 0);                  // inactive session
    send(idfc_pkg::CMD_START, idfc_pkg::SizeLimitRst);  // every sector erased
    send(idfc_pkg::CMD_ABORT, 0);
    send(idfc_pkg::CMD_START, 9);                 // partial word, padded at finish
    send(idfc_pkg::CMD_DATA, 32'h0000_0000);
    send(idfc_pkg::CMD_DATA, 32'hFFFF_FFFF, 1);
    for (int i = 0; i < 7; i++) send(idfc_pkg::CMD_DATA, $urandom);
    send(idfc_pkg::CMD_FINISH, sb.crc);
    send(idfc_pkg::CMD_COMMIT, 0);
    send(idfc_pkg::CMD_COMMIT, 0);
    drain();

    // Phase: extreme high limits, random idling, one full and one padded word.
    write_reg(idfc_pkg::CFG_SIZE_LIMIT, idfc_pkg::SizeLimitRst);
    write_reg(idfc_pkg::CFG_TIMEOUT, 20'hFFFFF);
    idling_on = 1'b1;
    send(idfc_pkg::CMD_START, 40);
    for (int i = 0; i < 40; i++) send(idfc_pkg::CMD_DATA, $urandom, i == 20);
    send(idfc_pkg::CMD_FINISH, sb.crc);
    send(idfc_pkg::CMD_COMMIT, 0);
    random_part(40);
    drain();

    // Phase: extreme low limits.
    write_reg(idfc_pkg::CFG_SIZE_LIMIT, 20'd1);
    write_reg(idfc_pkg::CFG_TIMEOUT, 20'd1);
    send(idfc_pkg::CMD_START, 2);
    send(idfc_pkg::CMD_START, 1);
    send(idfc_pkg::CMD_DATA, $urandom);
    send(idfc_pkg::CMD_DATA, $urandom);
    send(idfc_pkg::CMD_START, 1);
    send(idfc_pkg::CMD_TICK, 0);                  // times out at once
    send(idfc_pkg::CMD_START, 1);
    send(idfc_pkg::CMD_DATA, $urandom);
    send(idfc_pkg::CMD_FINISH, sb.crc);
    send(idfc_pkg::CMD_TICK, 0);
    send(idfc_pkg::CMD_COMMIT, 0);
    drain();

    // Phase: mid limits with short timeouts; last part without idling.
    write_reg(idfc_pkg::CFG_SIZE_LIMIT, 20'($urandom_range(20, 70)));
    write_reg(idfc_pkg::CFG_TIMEOUT, 20'($urandom_range(3, 12)));
    random_part(30);
    idling_on = 1'b0;
    random_part(25);

    in_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/idfc_pkg.sv
design/idfc_ram.sv
design/image_download_flash_controller_top.sv
verif/tb.sv
